// File: rtl/cmaf_pkg.sv
package cmaf_pkg;

   localparam int TURN         = 46080;
   localparam int HALF_TURN    = 23040;
   localparam int QUARTER_TURN = 11520;
   localparam int STEPS        = 16;
   localparam int STEP_W       = 4;
   localparam int GAIN_Q30     = 652032874;
   localparam int RIGHT_FINE   = 90 * 32768;
   localparam int ZW           = 25;
   localparam int ATAN_W       = 21;

   typedef enum logic [3:0] {
      S_BOOT0,
      S_BOOT0_RUN,
      S_BOOT0_SAVE,
      S_BOOT1,
      S_BOOT1_RUN,
      S_BOOT1_SAVE,
      S_INIT,
      S_IDLE,
      S_ROT,
      S_PAIR,
      S_ACC,
      S_VLOAD,
      S_VEC,
      S_FIN
   } state_type;

   typedef struct packed {
      logic boot_load;
      logic boot_neg;
      logic step;
      logic save_pose0;
      logic save_pose1;
      logic init_sums;
      logic accept;
      logic make_pair;
      logic accumulate;
      logic load_vec;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic last_step;
      logic joint_ok;
      logic rsp_busy;
   } status_type;

   function automatic logic [ATAN_W-1:0] atan_step(input logic [STEP_W-1:0] i);
      case (i)
         4'd0:    return 21'd1474560;
         4'd1:    return 21'd870484;
         4'd2:    return 21'd459940;
         4'd3:    return 21'd233473;
         4'd4:    return 21'd117189;
         4'd5:    return 21'd58653;
         4'd6:    return 21'd29333;
         4'd7:    return 21'd14667;
         4'd8:    return 21'd7334;
         4'd9:    return 21'd3667;
         4'd10:   return 21'd1833;
         4'd11:   return 21'd917;
         4'd12:   return 21'd458;
         4'd13:   return 21'd229;
         4'd14:   return 21'd115;
         4'd15:   return 21'd57;
         default: return '0;
      endcase
   endfunction

endpackage

// File: rtl/cmaf_if.sv
interface cmaf_req_if;
   logic               valid;
   logic               ready;
   logic [2:0]         joint;
   logic signed [15:0] angle;
   modport source (output valid, output joint, output angle, input ready);
   modport sink (input valid, input joint, input angle, output ready);
endinterface

interface cmaf_rsp_if;
   logic               valid;
   logic               ready;
   logic [2:0]         joint_out;
   logic signed [15:0] filtered_angle;
   modport source (output valid, output joint_out, output filtered_angle, input ready);
   modport sink (input valid, input joint_out, input filtered_angle, output ready);
endinterface

// File: rtl/cmaf_ctrl.sv
module cmaf_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  cmaf_pkg::status_type status,
   output cmaf_pkg::cmd_type    cmd
);

   cmaf_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= cmaf_pkg::S_BOOT0;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         cmaf_pkg::S_BOOT0:      state_in = cmaf_pkg::S_BOOT0_RUN;
         cmaf_pkg::S_BOOT0_RUN: begin
            if (status.last_step) state_in = cmaf_pkg::S_BOOT0_SAVE;
         end
         cmaf_pkg::S_BOOT0_SAVE: state_in = cmaf_pkg::S_BOOT1;
         cmaf_pkg::S_BOOT1:      state_in = cmaf_pkg::S_BOOT1_RUN;
         cmaf_pkg::S_BOOT1_RUN: begin
            if (status.last_step) state_in = cmaf_pkg::S_BOOT1_SAVE;
         end
         cmaf_pkg::S_BOOT1_SAVE: state_in = cmaf_pkg::S_INIT;
         cmaf_pkg::S_INIT:       state_in = cmaf_pkg::S_IDLE;
         cmaf_pkg::S_IDLE: begin
            if (req_valid) begin
               state_in = status.joint_ok ? cmaf_pkg::S_ROT : cmaf_pkg::S_FIN;
            end
         end
         cmaf_pkg::S_ROT: begin
            if (status.last_step) state_in = cmaf_pkg::S_PAIR;
         end
         cmaf_pkg::S_PAIR:       state_in = cmaf_pkg::S_ACC;
         cmaf_pkg::S_ACC:        state_in = cmaf_pkg::S_VLOAD;
         cmaf_pkg::S_VLOAD:      state_in = cmaf_pkg::S_VEC;
         cmaf_pkg::S_VEC: begin
            if (status.last_step) state_in = cmaf_pkg::S_FIN;
         end
         cmaf_pkg::S_FIN: begin
            if (!status.rsp_busy) state_in = cmaf_pkg::S_IDLE;
         end
         default:                state_in = cmaf_pkg::S_BOOT0;
      endcase
   end

   always_comb begin
      cmd       = '0;
      req_ready = 1'b0;
      case (state_ff)
         cmaf_pkg::S_BOOT0:      cmd.boot_load = 1'b1;
         cmaf_pkg::S_BOOT0_RUN:  cmd.step = 1'b1;
         cmaf_pkg::S_BOOT0_SAVE: cmd.save_pose0 = 1'b1;
         cmaf_pkg::S_BOOT1: begin
            cmd.boot_load = 1'b1;
            cmd.boot_neg  = 1'b1;
         end
         cmaf_pkg::S_BOOT1_RUN:  cmd.step = 1'b1;
         cmaf_pkg::S_BOOT1_SAVE: cmd.save_pose1 = 1'b1;
         cmaf_pkg::S_INIT:       cmd.init_sums = 1'b1;
         cmaf_pkg::S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
         end
         cmaf_pkg::S_ROT:        cmd.step = 1'b1;
         cmaf_pkg::S_PAIR:       cmd.make_pair = 1'b1;
         cmaf_pkg::S_ACC:        cmd.accumulate = 1'b1;
         cmaf_pkg::S_VLOAD:      cmd.load_vec = 1'b1;
         cmaf_pkg::S_VEC:        cmd.step = 1'b1;
         cmaf_pkg::S_FIN:        cmd.finish = !status.rsp_busy;
         default:                cmd = '0;
      endcase
   end

endmodule

// File: rtl/cmaf_datapath.sv
module cmaf_datapath #(
   parameter int WINDOW = 8,
   parameter int JOINTS = 7
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmaf_pkg::cmd_type    cmd,
   output cmaf_pkg::status_type status,
   input  logic [2:0]           req_joint,
   input  logic signed [15:0]   req_angle,
   input  logic                 rsp_ready,
   output logic                 rsp_valid,
   output logic [2:0]           rsp_joint_out,
   output logic signed [15:0]   rsp_filtered_angle
);

   localparam int DEPTH  = JOINTS * WINDOW;
   localparam int AW     = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int JW     = $clog2(JOINTS);
   localparam int JXW    = (JW > 3) ? JW : 3;
   localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int SW     = 17 + $clog2(WINDOW);
   localparam int CW     = (SW + 11 > 34) ? SW + 11 : 34;
   localparam int ZW     = cmaf_pkg::ZW;

   logic signed [CW-1:0]     x_ff, y_ff;
   logic signed [ZW-1:0]     z_ff;
   logic [cmaf_pkg::STEP_W-1:0] iter_ff;
   logic                     vec_ff, neg_ff, zero_ff;
   logic [2:0]               joint_ff;
   logic [JW-1:0]            jidx_ff;
   logic [AW-1:0]            addr_ff;
   logic [31:0]              rd_ff;
   logic signed [15:0]       pose0_c_ff, pose0_s_ff, pose1_c_ff, pose1_s_ff;
   logic signed [15:0]       pair_c_ff, pair_s_ff;
   logic signed [SW-1:0]     cos_sum_ff [JOINTS];
   logic signed [SW-1:0]     sin_sum_ff [JOINTS];
   logic [SLOT_W-1:0]        slot_ff [JOINTS];
   logic [JOINTS-1:0]        wrapped_ff;
   logic                     rsp_valid_ff;
   logic [2:0]               rsp_joint_ff;
   logic signed [15:0]       rsp_angle_ff;
   logic [31:0]              mem [DEPTH];

   logic signed [CW-1:0]     dx, dy;
   logic signed [ZW-1:0]     at_z;
   logic                     up;
   logic signed [16:0]       ang, r0, r1, r2;
   logic                     fold;
   logic [JXW-1:0]           jx;
   logic [JW-1:0]            jidx_req;
   logic                     joint_ok;
   logic [AW-1:0]            rd_addr;
   logic signed [15:0]       cur_c, cur_s, old_c, old_s, pose_c, pose_s;
   logic                     pose_neg;
   logic signed [SW-1:0]     sum_c, sum_s;
   logic signed [CW-1:0]     vx, vy;
   logic signed [15:0]       result;

   function automatic logic signed [15:0] to_q15(input logic signed [CW-1:0] v);
      logic [CW-1:0] mag, r;
      mag = v[CW-1] ? CW'(-v) : CW'(v);
      r   = (mag + CW'(16384)) >> 15;
      if (r > CW'(32767)) r = CW'(32767);
      return v[CW-1] ? -16'(r) : 16'(r);
   endfunction

   function automatic logic signed [15:0] to_deg(input logic signed [ZW-1:0] v);
      logic [ZW-1:0] mag, r;
      mag = v[ZW-1] ? ZW'(-v) : ZW'(v);
      r   = (mag + ZW'(128)) >> 8;
      if (r > ZW'(cmaf_pkg::HALF_TURN)) r = ZW'(cmaf_pkg::HALF_TURN);
      return v[ZW-1] ? -16'(r) : 16'(r);
   endfunction

   always_comb begin
      dx   = y_ff >>> iter_ff;
      dy   = x_ff >>> iter_ff;
      at_z = ZW'(cmaf_pkg::atan_step(iter_ff));
      up   = vec_ff ? y_ff[CW-1] : !z_ff[ZW-1];
   end

   always_comb begin
      ang = cmd.accept ? 17'(req_angle)
                       : (cmd.boot_neg ? -17'(cmaf_pkg::QUARTER_TURN) : '0);
      r0  = ang[16] ? ang + 17'(cmaf_pkg::TURN) : ang;
      r1  = (r0 > 17'(cmaf_pkg::HALF_TURN)) ? r0 - 17'(cmaf_pkg::TURN) : r0;
      fold = 1'b0;
      r2  = r1;
      if (r1 > 17'(cmaf_pkg::QUARTER_TURN)) begin
         r2   = r1 - 17'(cmaf_pkg::HALF_TURN);
         fold = 1'b1;
      end else if (r1 < -17'(cmaf_pkg::QUARTER_TURN)) begin
         r2   = r1 + 17'(cmaf_pkg::HALF_TURN);
         fold = 1'b1;
      end
   end

   always_comb begin
      jx       = JXW'(req_joint);
      joint_ok = 32'(req_joint) < JOINTS;
      jidx_req = joint_ok ? jx[JW-1:0] : '0;
      rd_addr  = AW'(int'(jidx_req) * WINDOW + int'(slot_ff[jidx_req]));
   end

   always_comb begin
      cur_c    = neg_ff ? -to_q15(x_ff) : to_q15(x_ff);
      cur_s    = neg_ff ? -to_q15(y_ff) : to_q15(y_ff);
      pose_neg = (joint_ff == 3'd0) || (joint_ff == 3'd1) || (joint_ff == 3'd3);
      pose_c   = pose_neg ? pose1_c_ff : pose0_c_ff;
      pose_s   = pose_neg ? pose1_s_ff : pose0_s_ff;
      old_c    = wrapped_ff[jidx_ff] ? rd_ff[31:16] : pose_c;
      old_s    = wrapped_ff[jidx_ff] ? rd_ff[15:0] : pose_s;
      sum_c    = cos_sum_ff[jidx_ff];
      sum_s    = sin_sum_ff[jidx_ff];
      vx       = CW'(sum_c) <<< 8;
      vy       = CW'(sum_s) <<< 8;
      result   = zero_ff ? '0 : to_deg(z_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.boot_load || cmd.accept) begin
         x_ff    <= CW'(cmaf_pkg::GAIN_Q30);
         y_ff    <= '0;
         z_ff    <= ZW'(r2) <<< 8;
         neg_ff  <= fold;
         vec_ff  <= 1'b0;
         iter_ff <= '0;
      end else if (cmd.load_vec) begin
         vec_ff  <= 1'b1;
         iter_ff <= '0;
         if (!sum_c[SW-1]) begin
            x_ff <= vx;
            y_ff <= vy;
            z_ff <= '0;
         end else if (!sum_s[SW-1]) begin
            x_ff <= vy;
            y_ff <= -vx;
            z_ff <= ZW'(cmaf_pkg::RIGHT_FINE);
         end else begin
            x_ff <= -vy;
            y_ff <= vx;
            z_ff <= -ZW'(cmaf_pkg::RIGHT_FINE);
         end
      end else if (cmd.step) begin
         iter_ff <= iter_ff + 1'b1;
         if (up) begin
            x_ff <= x_ff - dx;
            y_ff <= y_ff + dy;
            z_ff <= z_ff - at_z;
         end else begin
            x_ff <= x_ff + dx;
            y_ff <= y_ff - dy;
            z_ff <= z_ff + at_z;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.save_pose0) begin
         pose0_c_ff <= cur_c;
         pose0_s_ff <= cur_s;
      end
      if (cmd.save_pose1) begin
         pose1_c_ff <= cur_c;
         pose1_s_ff <= cur_s;
      end
      if (cmd.accept) begin
         joint_ff <= req_joint;
         jidx_ff  <= jidx_req;
         addr_ff  <= rd_addr;
         rd_ff    <= mem[rd_addr];
      end
      if (cmd.accept || cmd.load_vec) begin
         zero_ff <= cmd.accept ? !joint_ok : (sum_c == '0) && (sum_s == '0);
      end
      if (cmd.make_pair) begin
         pair_c_ff <= cur_c;
         pair_s_ff <= cur_s;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accumulate) begin
         mem[addr_ff] <= {pair_c_ff, pair_s_ff};
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.init_sums) begin
         for (int j = 0; j < JOINTS; j++) begin
            if (j == 0 || j == 1 || j == 3) begin
               cos_sum_ff[j] <= SW'(pose1_c_ff) * $signed(SW'(WINDOW));
               sin_sum_ff[j] <= SW'(pose1_s_ff) * $signed(SW'(WINDOW));
            end else begin
               cos_sum_ff[j] <= SW'(pose0_c_ff) * $signed(SW'(WINDOW));
               sin_sum_ff[j] <= SW'(pose0_s_ff) * $signed(SW'(WINDOW));
            end
         end
      end else if (cmd.accumulate) begin
         cos_sum_ff[jidx_ff] <= sum_c + SW'(pair_c_ff) - SW'(old_c);
         sin_sum_ff[jidx_ff] <= sum_s + SW'(pair_s_ff) - SW'(old_s);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int j = 0; j < JOINTS; j++) begin
            slot_ff[j] <= '0;
         end
         wrapped_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.accumulate) begin
            if (32'(slot_ff[jidx_ff]) >= WINDOW - 1) begin
               slot_ff[jidx_ff]    <= '0;
               wrapped_ff[jidx_ff] <= 1'b1;
            end else begin
               slot_ff[jidx_ff] <= slot_ff[jidx_ff] + 1'b1;
            end
         end
         if (cmd.finish) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         rsp_joint_ff <= joint_ff;
         rsp_angle_ff <= result;
      end
   end

   always_comb begin
      status.last_step = iter_ff == cmaf_pkg::STEP_W'(cmaf_pkg::STEPS - 1);
      status.joint_ok  = joint_ok;
      status.rsp_busy  = rsp_valid_ff && !rsp_ready;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_joint_out      = rsp_joint_ff;
   assign rsp_filtered_angle = rsp_angle_ff;

endmodule

// File: rtl/circular_mean_angle_filter.sv
// Moving circular mean of joint angles, one window of WINDOW samples per joint.
// A request transaction carries a joint index and an angle in 1/128 degree.
// Each request gives exactly one response transaction with the joint index and
// the circular mean of that joint's window, in 1/128 degree from -180 to 180.
// A joint index at or above JOINTS leaves the state alone and returns 0.
// One shared CORDIC unit does 16 rotation steps for sine and cosine, then 16
// vectoring steps for the angle of the running sums; it sets the rate.
// An unused joint index skips the CORDIC steps. A new request is taken only
// once the previous result has entered the output register.
// After reset the block computes the start pose and fills the running sums;
// req_ready stays low until then. The window memory holds
// no reset value; each joint's entries read as the start pose until that
// joint's window has been written through once.
// The response sits in an output register. While the receiver stalls the
// next request is still taken and processed, and its result waits until the
// register is free.
module circular_mean_angle_filter #(
   parameter int WINDOW = 8,
   parameter int JOINTS = 7
) (
   input logic        clock,
   input logic        reset,
   cmaf_req_if.sink   req_ch,
   cmaf_rsp_if.source rsp_ch
);

   cmaf_pkg::cmd_type    cmd;
   cmaf_pkg::status_type status;

   cmaf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .status    (status),
      .cmd       (cmd)
   );

   cmaf_datapath #(
      .WINDOW (WINDOW),
      .JOINTS (JOINTS)
   ) u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_joint          (req_ch.joint),
      .req_angle          (req_ch.angle),
      .rsp_ready          (rsp_ch.ready),
      .rsp_valid          (rsp_ch.valid),
      .rsp_joint_out      (rsp_ch.joint_out),
      .rsp_filtered_angle (rsp_ch.filtered_angle)
   );

endmodule

// File: rtl/cmaf_checker.sv
module cmaf_checker #(
   parameter int JOINTS = 7
) (
   input logic               clock,
   input logic               reset,
   input logic               req_valid,
   input logic               req_ready,
   input logic               rsp_valid,
   input logic               rsp_ready,
   input logic [2:0]         rsp_joint_out,
   input logic signed [15:0] rsp_filtered_angle
);

   // The block processes one request at a time.
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request taken while a transaction is in flight");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_ready)
      else $error("channel active right after reset");

   a_bad_joint_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (32'(rsp_joint_out) >= JOINTS) |-> rsp_filtered_angle == '0)
      else $error("unused joint index gave a nonzero angle");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

endmodule

bind circular_mean_angle_filter cmaf_checker #(
   .JOINTS (JOINTS)
) u_cmaf_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_ch.valid),
   .req_ready          (req_ch.ready),
   .rsp_valid          (rsp_ch.valid),
   .rsp_ready          (rsp_ch.ready),
   .rsp_joint_out      (rsp_ch.joint_out),
   .rsp_filtered_angle (rsp_ch.filtered_angle)
);
